@@ design/stereo_convolution_reverb_defines.svh @@
// Assertion macros for the stereo convolution reverb.
// Used by the top level; no other dependencies.
`ifndef STEREO_CONVOLUTION_REVERB_DEFINES_SVH
`define STEREO_CONVOLUTION_REVERB_DEFINES_SVH
`ifndef SYNTHESIS
`define SCR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SCR_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SCR_ASSERT(label, clk, rst_n, prop, msg)
`define SCR_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

@@ design/scr_pkg.sv @@
// Shared types and constants for the stereo convolution reverb.
// No dependencies.
package scr_pkg;
    localparam int MAX_TAPS     = 16384;
    localparam int MAX_PREDELAY = 4096;
    localparam int LANES        = 8;
    localparam int TAP_AW       = $clog2(MAX_TAPS);
    localparam int DLY_AW       = $clog2(MAX_PREDELAY);
    localparam int LANE_AW      = $clog2(LANES);
    localparam int ROW_AW       = TAP_AW - LANE_AW;
    localparam int ROWS         = MAX_TAPS / LANES;
    localparam int ACC_W        = 48;
    // Clearing pass covers every history row and every delay entry
    localparam int CLEAR_CYCLES = (ROWS > MAX_PREDELAY) ? ROWS : MAX_PREDELAY;

    localparam logic       OP_LOAD  = 1'b0;
    localparam logic       OP_FRAME = 1'b1;

    localparam logic [2:0] REG_ENABLE   = 3'd0;
    localparam logic [2:0] REG_IR_LEN   = 3'd1;
    localparam logic [2:0] REG_WET_MIX  = 3'd2;
    localparam logic [2:0] REG_PREDELAY = 3'd3;
    localparam logic [2:0] REG_CHANNELS = 3'd4;

    typedef struct packed {
        logic               op;
        logic [13:0]        tap_index;
        logic signed [15:0] tap_left;
        logic signed [15:0] tap_right;
        logic signed [15:0] left_in;
        logic signed [15:0] right_in;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
    } out_item_t;

    // Lane command from the sequencer.
    typedef struct packed {
        logic              clear;    // start of a convolution pass
        logic              mac;      // row valid for accumulate
        logic [LANE_AW:0]  lane_cnt; // lanes active in this row
    } lane_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CLEAR, ST_RUN, ST_DRAIN, ST_DELAY, ST_MIX, ST_WET, ST_OUT
    } state_t;

    function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
        if (v > 48'sd32767)       return 16'sh7fff;
        else if (v < -48'sd32768) return 16'sh8000;
        else                      return v[15:0];
    endfunction
endpackage

@@ design/scr_lane.sv @@
// One MAC lane: owns one bank of taps and history for each channel.
// Depends on scr_pkg.
module scr_lane (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          tap_we,
    input  logic [scr_pkg::ROW_AW-1:0]    tap_addr,
    input  logic signed [15:0]            tap_l_wdata,
    input  logic signed [15:0]            tap_r_wdata,
    input  logic                          hist_we,
    input  logic                          hist_we_r,
    input  logic [scr_pkg::ROW_AW-1:0]    hist_waddr,
    input  logic signed [15:0]            hist_l_wdata,
    input  logic signed [15:0]            hist_r_wdata,
    input  logic [scr_pkg::ROW_AW-1:0]    tap_raddr,
    input  logic [scr_pkg::ROW_AW-1:0]    hist_raddr,
    input  logic                          rd_en,
    output logic signed [15:0]            hist_l_q,
    output logic signed [15:0]            hist_r_q,
    input  logic signed [15:0]            mul_hl,
    input  logic signed [15:0]            mul_hr,
    input  logic                          mac_en,
    input  logic                          acc_clear,
    output logic signed [scr_pkg::ACC_W-1:0] acc_l,
    output logic signed [scr_pkg::ACC_W-1:0] acc_r
);
    import scr_pkg::*;

    logic signed [15:0] tap_l_mem [ROWS];
    logic signed [15:0] tap_r_mem [ROWS];
    logic signed [15:0] hist_l_mem [ROWS];
    logic signed [15:0] hist_r_mem [ROWS];
    logic signed [15:0] tl_reg, tr_reg, hl_reg, hr_reg;
    logic signed [31:0] pl_reg, pr_reg;
    logic               mv_reg;
    logic               pv_reg;
    logic signed [ACC_W-1:0] accl_reg, accr_reg;

    // Tap banks
    always_ff @(posedge clk)
    begin
        if (tap_we)
        begin
            tap_l_mem[tap_addr] <= tap_l_wdata;
            tap_r_mem[tap_addr] <= tap_r_wdata;
        end
        if (rd_en)
        begin
            tl_reg <= tap_l_mem[tap_raddr];
            tr_reg <= tap_r_mem[tap_raddr];
        end
    end

    // History banks (cleared by sweep after reset)
    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_l_mem[hist_waddr] <= hist_l_wdata;
        if (hist_we_r)
            hist_r_mem[hist_waddr] <= hist_r_wdata;
        if (rd_en)
        begin
            hl_reg <= hist_l_mem[hist_raddr];
            hr_reg <= hist_r_mem[hist_raddr];
        end
    end

    // History read data goes out to the crossbar; the matching sample comes back
    assign hist_l_q = hl_reg;
    assign hist_r_q = hr_reg;

    // Product stage
    always_ff @(posedge clk)
    begin
        pl_reg <= tl_reg * mul_hl;
        pr_reg <= tr_reg * mul_hr;
    end

    // Valid follows read then product; accumulate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg   <= 1'b0;
            pv_reg   <= 1'b0;
            accl_reg <= '0;
            accr_reg <= '0;
        end
        else
        begin
            mv_reg <= mac_en;
            pv_reg <= mv_reg;
            if (acc_clear)
            begin
                accl_reg <= '0;
                accr_reg <= '0;
            end
            else if (pv_reg)
            begin
                accl_reg <= accl_reg + ACC_W'(pl_reg);
                accr_reg <= accr_reg + ACC_W'(pr_reg);
            end
        end
    end

    assign acc_l = accl_reg;
    assign acc_r = accr_reg;
endmodule

@@ design/scr_merge.sv @@
// Merge stage: registered adder tree over the lane accumulators.
// Depends on scr_pkg.
module scr_merge (
    input  logic                                clk,
    input  logic signed [scr_pkg::ACC_W-1:0]    acc_l [scr_pkg::LANES],
    input  logic signed [scr_pkg::ACC_W-1:0]    acc_r [scr_pkg::LANES],
    output logic signed [scr_pkg::ACC_W-1:0]    sum_l,
    output logic signed [scr_pkg::ACC_W-1:0]    sum_r
);
    import scr_pkg::*;

    logic signed [ACC_W-1:0] l1_reg [LANES/2];
    logic signed [ACC_W-1:0] r1_reg [LANES/2];
    logic signed [ACC_W-1:0] sl_reg, sr_reg;

    // First level registered, second level summed into output register
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LANES/2; i++)
        begin
            l1_reg[i] <= acc_l[2*i] + acc_l[2*i+1];
            r1_reg[i] <= acc_r[2*i] + acc_r[2*i+1];
        end
    end

    always_comb
    begin
        sum_l = sl_reg;
        sum_r = sr_reg;
    end

    always_ff @(posedge clk)
    begin
        logic signed [ACC_W-1:0] tl, tr;
        tl = '0;
        tr = '0;
        for (int i = 0; i < LANES/2; i++)
        begin
            tl = tl + l1_reg[i];
            tr = tr + r1_reg[i];
        end
        sl_reg <= tl;
        sr_reg <= tr;
    end
endmodule

@@ design/scr_delay.sv @@
// Pre-delay ring for both wet channels.
// Depends on scr_pkg.
module scr_delay (
    input  logic                         clk,
    input  logic                         we,
    input  logic                         we_r,
    input  logic [scr_pkg::DLY_AW-1:0]   waddr,
    input  logic signed [15:0]           wl,
    input  logic signed [15:0]           wr,
    input  logic                         rd_en,
    input  logic [scr_pkg::DLY_AW-1:0]   raddr,
    output logic signed [15:0]           rl,
    output logic signed [15:0]           rr
);
    import scr_pkg::*;

    logic signed [15:0] dl_mem [MAX_PREDELAY];
    logic signed [15:0] dr_mem [MAX_PREDELAY];
    logic signed [15:0] rl_reg, rr_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            dl_mem[waddr] <= wl;
        if (we_r)
            dr_mem[waddr] <= wr;
        if (rd_en)
        begin
            rl_reg <= dl_mem[raddr];
            rr_reg <= dr_mem[raddr];
        end
    end

    assign rl = rl_reg;
    assign rr = rr_reg;
endmodule

@@ design/stereo_convolution_reverb.sv @@
// Stereo convolution reverb: 8 MAC lanes, each owning 1/8 of taps/history.
// Frames are processed one at a time: an item is accepted only in ST_IDLE with no
// result waiting, so a new frame is not taken before the previous result is taken.
// Load items and bypass frames are handled in ST_IDLE. After reset a clearing pass
// zeroes history and delay lines; no item is accepted during it.
// Depends on scr_pkg, scr_lane, scr_merge, scr_delay, defines header.
`include "stereo_convolution_reverb_defines.svh"
module stereo_convolution_reverb (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  scr_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output scr_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import scr_pkg::*;

    // Configuration
    logic        enable_reg;
    logic [14:0] ir_len_reg;
    logic [15:0] wet_mix_reg;
    logic [11:0] pre_delay_reg;
    logic [1:0]  chan_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b1;
            ir_len_reg    <= '0;
            wet_mix_reg   <= 16'd9830;
            pre_delay_reg <= '0;
            chan_reg      <= 2'd2;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ENABLE:   enable_reg    <= cfg_data[0];
                REG_IR_LEN:   ir_len_reg    <= cfg_data[14:0];
                REG_WET_MIX:  wet_mix_reg   <= cfg_data;
                REG_PREDELAY: pre_delay_reg <= cfg_data[11:0];
                REG_CHANNELS: chan_reg      <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Control state
    state_t              state_reg, state_next;
    in_item_t            item_reg;
    logic [TAP_AW-1:0]   hptr_reg;
    logic [DLY_AW-1:0]   dptr_reg;
    logic [TAP_AW:0]     cnt_reg;      // taps issued / clear sweep index
    logic [TAP_AW-1:0]   pos_reg;      // history position of tap cnt
    logic [3:0]          drain_reg;
    logic                mono_reg;
    logic [TAP_AW:0]     len_reg;
    logic [15:0]         mix_reg;
    logic [16:0]         dry_gain;
    logic signed [31:0]  dry_l_reg, dry_r_reg, wmul_l_reg, wmul_r_reg;
    out_item_t           out_reg;
    logic                out_v_reg;
    logic                bypass;
    logic                accept;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE) && !out_v_reg;
    assign out_valid = out_v_reg;
    assign out_data  = out_reg;
    assign bypass    = !enable_reg || (ir_len_reg == '0);
    assign dry_gain  = 17'd32768 - {1'b0, mix_reg};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (cnt_reg == (TAP_AW+1)'(CLEAR_CYCLES - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (accept && in_data.op == OP_FRAME && !bypass) state_next = ST_RUN;
            ST_RUN:   if (cnt_reg + (TAP_AW+1)'(LANES) >= len_reg) state_next = ST_DRAIN;
            ST_DRAIN: if (drain_reg == 4'd7) state_next = ST_DELAY;
            ST_DELAY: state_next = ST_MIX;
            ST_MIX:   state_next = ST_WET;
            ST_WET:   state_next = ST_OUT;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Lane addressing: tap k lives in lane k%8, row k/8; history position p in
    // lane p%8, row p/8. A row pass needs positions pos..pos-7, so bank b reads
    // position pos-((s-b)%8) with s = hptr%8, and a rotating crossbar hands the
    // sample of bank (s-g)%8 to the multiplier of lane g.
    logic signed [ACC_W-1:0] acc_l [LANES];
    logic signed [ACC_W-1:0] acc_r [LANES];
    logic signed [15:0]      hq_l [LANES];
    logic signed [15:0]      hq_r [LANES];
    logic signed [ACC_W-1:0] sum_l, sum_r;
    logic                    running;
    logic                    clearing;
    assign running  = (state_reg == ST_RUN);
    assign clearing = (state_reg == ST_CLEAR);

    logic hist_first;
    assign hist_first = accept && in_data.op == OP_FRAME && !bypass;
    logic load_now;
    assign load_now = accept && in_data.op == OP_LOAD;

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        logic [LANE_AW-1:0] hsel;
        logic [TAP_AW-1:0]  p;
        logic               act;
        // bank offset for this lane's read, and source bank for its multiplier
        assign hsel = hptr_reg[LANE_AW-1:0] - LANE_AW'(g);
        assign p    = pos_reg - TAP_AW'(hsel);
        assign act  = running && ((cnt_reg + (TAP_AW+1)'(g)) < len_reg);
        scr_lane u_lane (
            .clk          (clk),
            .rst_n        (rst_n),
            .tap_we       (load_now && in_data.tap_index[LANE_AW-1:0] == LANE_AW'(g)),
            .tap_addr     (in_data.tap_index[TAP_AW-1:LANE_AW]),
            .tap_l_wdata  (in_data.tap_left),
            .tap_r_wdata  (in_data.tap_right),
            .hist_we      (clearing || (hist_first
                           && hptr_reg[LANE_AW-1:0] == LANE_AW'(g))),
            .hist_we_r    (clearing || (hist_first && chan_reg != 2'd1
                           && hptr_reg[LANE_AW-1:0] == LANE_AW'(g))),
            .hist_waddr   (clearing ? cnt_reg[ROW_AW-1:0] : hptr_reg[TAP_AW-1:LANE_AW]),
            .hist_l_wdata (clearing ? 16'sd0 : in_data.left_in),
            .hist_r_wdata (clearing ? 16'sd0 : in_data.right_in),
            .tap_raddr    (cnt_reg[TAP_AW-1:LANE_AW]),
            .hist_raddr   (p[TAP_AW-1:LANE_AW]),
            .rd_en        (running),
            .hist_l_q     (hq_l[g]),
            .hist_r_q     (hq_r[g]),
            .mul_hl       (hq_l[hsel]),
            .mul_hr       (hq_r[hsel]),
            .mac_en       (act),
            .acc_clear    (hist_first),
            .acc_l        (acc_l[g]),
            .acc_r        (acc_r[g])
        );
    end

    // Note: each lane reads exactly one tap per row pass; tap cnt+g always maps
    // to lane (cnt+g)%8 = g because cnt steps by 8 from zero.

    scr_merge u_merge (
        .clk   (clk),
        .acc_l (acc_l),
        .acc_r (acc_r),
        .sum_l (sum_l),
        .sum_r (sum_r)
    );

    // Wet values after shift and saturation
    logic signed [15:0] wl_c, wr_c, dly_l, dly_r;
    assign wl_c = sat16(sum_l >>> 15);
    assign wr_c = sat16(sum_r >>> 15);

    // Read pointer trails the entry written in ST_DELAY by pre_delay
    logic [DLY_AW-1:0] rd_addr;
    assign rd_addr = dptr_reg - pre_delay_reg;

    scr_delay u_delay (
        .clk   (clk),
        .we    (clearing ? 1'b1 : (state_reg == ST_DELAY)),
        .we_r  (clearing ? 1'b1 : (state_reg == ST_DELAY && !mono_reg)),
        .waddr (clearing ? DLY_AW'(cnt_reg) : dptr_reg),
        .wl    (clearing ? 16'sd0 : wl_c),
        .wr    (clearing ? 16'sd0 : wr_c),
        .rd_en (state_reg == ST_MIX),
        .raddr (rd_addr),
        .rl    (dly_l),
        .rr    (dly_r)
    );

    // Datapath and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            hptr_reg  <= '0;
            dptr_reg  <= '0;
            cnt_reg   <= '0;
            pos_reg   <= '0;
            out_v_reg <= 1'b0;
            out_reg   <= '0;
            drain_reg <= '0;
            dry_l_reg <= '0;
            dry_r_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_v_reg && out_ready)
                out_v_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR:
                begin
                    if (state_next == ST_IDLE)
                        cnt_reg <= '0;
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                ST_IDLE:
                begin
                    if (accept && in_data.op == OP_FRAME)
                    begin
                        if (bypass)
                        begin
                            out_reg.left_out  <= in_data.left_in;
                            out_reg.right_out <= in_data.right_in;
                            out_v_reg         <= 1'b1;
                        end
                        cnt_reg <= '0;
                        pos_reg <= hptr_reg;
                    end
                end
                ST_RUN:
                begin
                    cnt_reg   <= cnt_reg + (TAP_AW+1)'(LANES);
                    pos_reg   <= pos_reg - TAP_AW'(LANES);
                    drain_reg <= '0;
                end
                ST_DRAIN:
                    drain_reg <= drain_reg + 1'b1;
                ST_DELAY:
                    hptr_reg <= hptr_reg + 1'b1;
                ST_MIX:
                begin
                    dptr_reg  <= dptr_reg + 1'b1;
                    dry_l_reg <= 32'(item_reg.left_in) * 32'($signed(dry_gain));
                    dry_r_reg <= 32'(item_reg.right_in) * 32'($signed(dry_gain));
                end
                ST_OUT:
                begin
                    out_reg.left_out  <= sat16((ACC_W'(dry_l_reg) + ACC_W'(wmul_l_reg)) >>> 15);
                    out_reg.right_out <= mono_reg
                        ? sat16((ACC_W'(dry_l_reg) + ACC_W'(wmul_l_reg)) >>> 15)
                        : sat16((ACC_W'(dry_r_reg) + ACC_W'(wmul_r_reg)) >>> 15);
                    out_v_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Wet multiply: delayed sample is valid in ST_WET, product used in ST_OUT
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
            mono_reg <= (chan_reg == 2'd1);
            len_reg  <= (ir_len_reg > 15'(MAX_TAPS)) ? (TAP_AW+1)'(MAX_TAPS)
                                                     : (TAP_AW+1)'(ir_len_reg);
            mix_reg  <= (wet_mix_reg > 16'd32768) ? 16'd32768 : wet_mix_reg;
        end
        wmul_l_reg <= 32'(dly_l) * 32'($signed({1'b0, mix_reg}));
        wmul_r_reg <= 32'(dly_r) * 32'($signed({1'b0, mix_reg}));
    end

    // Assertions
    `SCR_ASSERT(a_no_accept_busy, clk, rst_n, (state_reg != ST_IDLE) |-> !in_ready, "accepted while busy")
    `SCR_ASSERT(a_out_after_mix, clk, rst_n, (state_reg == ST_OUT) |=> out_valid, "no result after mix")
    `SCR_ASSERT(a_hold_out, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_data)), "output dropped")
endmodule

@@ sim/tb_stereo_convolution_reverb.sv @@
// Self-checking testbench for stereo_convolution_reverb: tap loads and stereo frames
// against an in-bench predictor, with random idling on both channels and config phases.
// Depends on scr_pkg and the stereo_convolution_reverb RTL.
module tb_stereo_convolution_reverb;
    import scr_pkg::*;

    localparam int WATCHDOG_LIMIT = 30000;
    localparam int LONG_STALL     = 3000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    in_item_t   in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_item_t  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    stereo_convolution_reverb dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // Predictor state
    logic signed [15:0] tap_l [MAX_TAPS];
    logic signed [15:0] tap_r [MAX_TAPS];
    logic signed [15:0] hist_l [MAX_TAPS];
    logic signed [15:0] hist_r [MAX_TAPS];
    logic signed [15:0] dly_l [MAX_PREDELAY];
    logic signed [15:0] dly_r [MAX_PREDELAY];
    int unsigned hist_ptr = 0;
    int unsigned dly_ptr = 0;

    logic        cur_enable = 1'b1;
    logic [14:0] cur_ir_len = 15'd0;
    logic [15:0] cur_wet = 16'd9830;
    logic [11:0] cur_predelay = 12'd0;
    logic [1:0]  cur_channels = 2'd2;

    in_item_t  pending_items [$];
    out_item_t expected_frames [$];
    int errors = 0;
    int frames_seen = 0;
    int loaded_upto = 0;
    bit accepted_any;

    function automatic longint sat_sample(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint fir_sum(bit right_ch, int unsigned n);
        longint acc;
        int unsigned pos;
        acc = 0;
        pos = hist_ptr;
        for (int unsigned i = 0; i < n; i++)
        begin
            if (right_ch)
                acc += longint'(tap_r[i]) * longint'(hist_r[pos]);
            else
                acc += longint'(tap_l[i]) * longint'(hist_l[pos]);
            pos = (pos == 0) ? MAX_TAPS - 1 : pos - 1;
        end
        return sat_sample(acc >>> 15);
    endfunction

    function automatic longint wet_dry_mix(longint dry, longint wet, longint m);
        return sat_sample((dry * (32768 - m) + wet * m) >>> 15);
    endfunction

    // Works out the result of one accepted item and updates the block state
    task automatic reverb_predict(input in_item_t it);
        out_item_t   res;
        longint      wl;
        longint      wr;
        longint      m;
        int unsigned n;
        int unsigned rd;
        bit          mono;
        wr = 0;
        if (it.op == OP_LOAD)
        begin
            tap_l[it.tap_index] = it.tap_left;
            tap_r[it.tap_index] = it.tap_right;
            return;
        end
        if (!cur_enable || cur_ir_len == 0)
        begin
            res.left_out  = it.left_in;
            res.right_out = it.right_in;
            expected_frames.push_back(res);
            return;
        end
        m    = (cur_wet > 16'd32768) ? 32768 : cur_wet;
        n    = (cur_ir_len > MAX_TAPS) ? MAX_TAPS : cur_ir_len;
        mono = (cur_channels == 2'd1);
        hist_l[hist_ptr] = it.left_in;
        wl = fir_sum(1'b0, n);
        if (!mono)
        begin
            hist_r[hist_ptr] = it.right_in;
            wr = fir_sum(1'b1, n);
        end
        hist_ptr = (hist_ptr + 1) % MAX_TAPS;
        // wet sample goes in first, then is read back pre_delay entries behind
        rd = (dly_ptr + MAX_PREDELAY - cur_predelay) % MAX_PREDELAY;
        dly_l[dly_ptr] = wl[15:0];
        wl = dly_l[rd];
        if (!mono)
        begin
            dly_r[dly_ptr] = wr[15:0];
            wr = dly_r[rd];
        end
        dly_ptr = (dly_ptr + 1) % MAX_PREDELAY;
        res.left_out  = 16'(wet_dry_mix(it.left_in, wl, m));
        res.right_out = mono ? res.left_out : 16'(wet_dry_mix(it.right_in, wr, m));
        expected_frames.push_back(res);
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("error: %s got %h expected %h", what, got, want);
        errors++;
    endtask

    // Input driver: bursts of random length with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                reverb_predict(in_data);
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_items.pop_front();
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output receiver: own stall pattern, plus one long hold-off
    int stall_left = 0;
    bit long_stall_done = 1'b0;
    int unsigned rx_cycle = 0;
    always @(posedge clk)
    begin
        rx_cycle++;
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (!long_stall_done && frames_seen == 60)
        begin
            long_stall_done = 1'b1;
            stall_left = LONG_STALL;
            out_ready <= 1'b0;
        end
        else if (rx_cycle[6])
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 2) != 0);
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            frames_seen++;
            if (expected_frames.size() == 0)
            begin
                $display("error: output frame with no expected frame pending");
                errors++;
            end
            else
            begin
                if (out_data.left_out !== expected_frames[0].left_out)
                    report_mismatch("left_out", out_data.left_out,
                                    expected_frames[0].left_out);
                if (out_data.right_out !== expected_frames[0].right_out)
                    report_mismatch("right_out", out_data.right_out,
                                    expected_frames[0].right_out);
                void'(expected_frames.pop_front());
            end
        end
    end

    // Watchdog on cycles with no transfer at all
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        accepted_any = (in_valid && in_ready) || (out_valid && out_ready)
                       || (cfg_valid && cfg_ready);
        idle_cycles = accepted_any ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("stereo_convolution_reverb: mismatch");
            $finish;
        end
    end

    // Stimulus helpers
    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_frame(input logic signed [15:0] l, input logic signed [15:0] r);
        in_item_t it;
        it = '0;
        it.op        = OP_FRAME;
        it.tap_index = 14'($urandom);
        it.tap_left  = 16'($urandom);
        it.tap_right = 16'($urandom);
        it.left_in   = l;
        it.right_in  = r;
        pending_items.push_back(it);
    endtask

    task automatic add_load(input int idx, input logic signed [15:0] tl,
                            input logic signed [15:0] tr);
        in_item_t it;
        it = '0;
        it.op        = OP_LOAD;
        it.tap_index = 14'(idx);
        it.tap_left  = tl;
        it.tap_right = tr;
        it.left_in   = 16'($urandom);
        it.right_in  = 16'($urandom);
        pending_items.push_back(it);
    endtask

    // Loads taps 0..n-1 so that no unwritten tap is ever read
    task automatic load_taps_upto(input int n);
        while (loaded_upto < n)
        begin
            add_load(loaded_upto, rand_sample() >>> $urandom_range(0, 3),
                     rand_sample() >>> $urandom_range(0, 3));
            loaded_upto++;
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_ENABLE:   cur_enable   = value[0];
            REG_IR_LEN:   cur_ir_len   = value[14:0];
            REG_WET_MIX:  cur_wet      = value;
            REG_PREDELAY: cur_predelay = value[11:0];
            REG_CHANNELS: cur_channels = value[1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic en, input logic [14:0] len, input logic [15:0] wet,
                             input logic [11:0] pd, input logic [1:0] ch);
        write_reg(REG_ENABLE,   {15'($urandom), en});
        write_reg(REG_IR_LEN,   {1'($urandom), len});
        write_reg(REG_WET_MIX,  wet);
        write_reg(REG_PREDELAY, {4'($urandom), pd});
        write_reg(REG_CHANNELS, {14'($urandom), ch});
    endtask

    // Sender pause: wait until everything is out, then let the block settle
    task automatic drain();
        wait (pending_items.size() == 0 && !in_valid && expected_frames.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        logic [14:0] len;
        logic [15:0] wet;
        logic [11:0] pd;
        for (int i = 0; i < MAX_TAPS; i++)
        begin
            hist_l[i] = '0;
            hist_r[i] = '0;
        end
        for (int i = 0; i < MAX_PREDELAY; i++)
        begin
            dly_l[i] = '0;
            dly_r[i] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset config bypasses since ir_length is zero
        add_frame(16'sh7fff, 16'sh8000);
        add_frame(16'sh8000, 16'sh7fff);
        add_frame(16'sh0000, -16'sd1);
        add_load(16383, 16'sh8000, 16'sh7fff);
        add_load(14'h2aaa, 16'sh7fff, 16'sh8000);
        add_load(0, 16'sh7fff, 16'sh7fff);
        add_load(1, 16'sh7fff, 16'sh8000);
        add_load(2, 16'sh8000, 16'sh7fff);
        add_load(3, 16'sh7fff, 16'sh7fff);
        loaded_upto = 4;
        drain();

        // Directed: full wet, saturating taps
        write_all(1'b1, 15'd4, 16'd32768, 12'd0, 2'd2);
        add_frame(16'sh7fff, 16'sh8000);
        add_frame(16'sh7fff, 16'sh8000);
        add_frame(16'sh8000, 16'sh7fff);
        add_frame(16'sh8000, 16'sh8000);
        drain();
        // Directed: dry only, pre-delay, mono, odd channel count, clamped wet
        write_all(1'b1, 15'd3, 16'd0, 12'd2, 2'd1);
        add_frame(16'sh1234, 16'sh7fff);
        add_frame(16'sh8000, 16'sh0001);
        drain();
        write_all(1'b1, 15'd4, 16'hffff, 12'd4095, 2'd3);
        add_frame(16'sh4000, 16'shc000);
        add_frame(16'sh7fff, 16'sh8000);
        drain();
        write_all(1'b1, 15'd2, 16'd16384, 12'd1, 2'd0);
        add_frame(16'sh0100, 16'shff00);
        add_frame(16'sh7fff, 16'sh7fff);
        add_frame(16'sh8000, 16'sh8000);
        drain();

        // Random phases
        for (int ph = 0; ph < 9; ph++)
        begin
            case ($urandom_range(0, 5))
                0: len = 15'd1;
                1: len = 15'd64;
                default: len = 15'($urandom_range(1, 40));
            endcase
            case ($urandom_range(0, 4))
                0: wet = 16'd0;
                1: wet = 16'd32768;
                2: wet = 16'hffff;
                default: wet = 16'($urandom_range(0, 32768));
            endcase
            case ($urandom_range(0, 4))
                0: pd = 12'd4095;
                1: pd = 12'd0;
                2: pd = 12'($urandom);
                default: pd = 12'($urandom_range(1, 24));
            endcase
            if (ph == 3)
                // longest ir_length only with reverb off: taps are never read
                write_all(1'b0, 15'h7fff, wet, pd, 2'($urandom));
            else
                write_all(($urandom_range(0, 6) != 0), len, wet, pd, 2'($urandom));
            if (ph != 3)
                load_taps_upto(len);
            for (int k = 0; k < 28; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    add_load($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 63),
                             rand_sample(), rand_sample());
                else
                    add_frame(rand_sample(), rand_sample());
            end
            drain();
        end

        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("stereo_convolution_reverb: match");
        else
            $display("stereo_convolution_reverb: mismatch");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+design
design/scr_pkg.sv
design/scr_lane.sv
design/scr_merge.sv
design/scr_delay.sv
design/stereo_convolution_reverb.sv
sim/tb_stereo_convolution_reverb.sv
